[rtl/box_filter_premult_downscale_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the box-filter downscaler
// Checks are sampled on clk and are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef BOX_FILTER_PREMULT_DOWNSCALE_MACROS_SVH
`define BOX_FILTER_PREMULT_DOWNSCALE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box filter check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box filter check failed");

`endif

[rtl/bfpd_pkg.sv]
// ---------------------------------------------------------------------------
// bfpd_pkg
// Shared sizes, register codes, queue entry type and premultiply helper.
// ---------------------------------------------------------------------------
package bfpd_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = IDX_W + 1;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 25;
  localparam int CFG_IDX_W = 3;
  localparam int Q_DEPTH   = 4;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = Q_PTR_W + 1;

  localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [CNT_W-1:0] cnt;
  } acc_t;

  typedef struct packed {
    acc_t             acc;
    logic [IDX_W-1:0] x;
    logic [IDX_W-1:0] y;
    logic             last;
  } box_t;

  // floor(c*a/255), exact over the 8x8 bit product range
  function automatic logic [7:0] premult(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] x;
    logic [16:0] t;
    x = {9'd0, c} * {9'd0, a};
    t = x + (x >> 8) + 17'd1;
    return t[15:8];
  endfunction

endpackage

[rtl/bfpd_div.sv]
// ---------------------------------------------------------------------------
// bfpd_div
// Restoring 32/32 unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bfpd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  step;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  assign rem_sh   = {rem, quo[31]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
      step <= step + 5'd1;
      if (step == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

[rtl/bfpd_queue.sv]
// ---------------------------------------------------------------------------
// bfpd_queue
// Small FIFO of finished boxes between the accumulate and divide sides.
// ---------------------------------------------------------------------------
module bfpd_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  bfpd_pkg::box_t               wr_data,
  input  logic                         rd_en,
  output bfpd_pkg::box_t               rd_data,
  output logic                         q_empty,
  output logic [bfpd_pkg::Q_CNT_W-1:0] count
);

  bfpd_pkg::box_t                 slots [bfpd_pkg::Q_DEPTH];
  logic [bfpd_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [bfpd_pkg::Q_PTR_W-1:0]   rd_ptr;

  assign rd_data = slots[rd_ptr];
  assign q_empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/bfpd_front.sv]
// ---------------------------------------------------------------------------
// bfpd_front
// Config registers, raster walk, box accumulator memory and clearing pass.
// ---------------------------------------------------------------------------
module bfpd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr,
  input  logic [bfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfpd_pkg::DIM_W-1:0]       cfg_data,
  input  logic                             push,
  input  logic [31:0]                      src_pixel,
  input  logic [bfpd_pkg::Q_CNT_W-1:0]     q_count,
  output logic                             full,
  output logic                             q_push,
  output bfpd_pkg::box_t                   q_data
);

  localparam logic [bfpd_pkg::DIM_W-1:0] DimMax  = bfpd_pkg::DIM_W'(bfpd_pkg::MAX_DIM);
  localparam logic [bfpd_pkg::IDX_W-1:0] IdxLast = bfpd_pkg::IDX_W'(bfpd_pkg::MAX_DIM - 1);
  localparam logic [bfpd_pkg::Q_CNT_W-1:0] QStop = bfpd_pkg::Q_CNT_W'(bfpd_pkg::Q_DEPTH - 1);

  logic [bfpd_pkg::DIM_W-1:0] src_width, src_height, dst_width, dst_height;
  logic                       clearing;
  logic [bfpd_pkg::IDX_W-1:0] clr_cnt;

  logic [bfpd_pkg::IDX_W-1:0] src_col, src_row, dst_col, dst_row;
  // distance terms: (k+1)*src - (pos+1)*dst, box ends where it drops below dst
  logic [bfpd_pkg::IDX_W-1:0] col_err, row_err;

  logic sizes_ok, accept, take;
  logic col_end, row_end, line_end, frame_end;
  logic [bfpd_pkg::DIM_W-1:0] col_sub, row_sub, col_init, row_init;

  bfpd_pkg::acc_t mem [bfpd_pkg::MAX_DIM];
  bfpd_pkg::acc_t rdata, cur, nsum, wb_data, fwd_data;
  logic           fwd_valid;

  logic                       s1_valid, s1_emit, s1_last;
  logic [bfpd_pkg::IDX_W-1:0] s1_idx, s1_y;
  logic [7:0]                 s1_pa, s1_pr, s1_pg, s1_pb;

  assign sizes_ok = (src_width != '0) && (src_height != '0) &&
                    (dst_width != '0) && (dst_height != '0) &&
                    (src_width <= DimMax) && (src_height <= DimMax) &&
                    (dst_width <= src_width) && (dst_height <= src_height);

  assign full   = clearing || (q_count >= QStop);
  assign accept = push && !full;
  assign take   = accept && sizes_ok;

  assign col_end   = {1'b0, col_err} < dst_width;
  assign row_end   = {1'b0, row_err} < dst_height;
  assign line_end  = ({1'b0, src_col} + 1'b1) == src_width;
  assign frame_end = ({1'b0, src_row} + 1'b1) == src_height;
  assign col_sub   = {1'b0, col_err} - dst_width;
  assign row_sub   = {1'b0, row_err} - dst_height;
  assign col_init  = src_width - dst_width;
  assign row_init  = src_height - dst_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bfpd_pkg::DIM_W'(1);
      src_height <= bfpd_pkg::DIM_W'(1);
      dst_width  <= bfpd_pkg::DIM_W'(1);
      dst_height <= bfpd_pkg::DIM_W'(1);
      clearing   <= 1'b1;
      clr_cnt    <= '0;
      s1_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
      src_col    <= '0;
      src_row    <= '0;
      dst_col    <= '0;
      dst_row    <= '0;
      col_err    <= '0;
      row_err    <= '0;
    end else begin
      s1_valid  <= take;
      fwd_valid <= take && s1_valid && (dst_col == s1_idx);
      if (cfg_wr) begin
        case (cfg_index)
          bfpd_pkg::REG_SRC_WIDTH: begin
            src_width <= cfg_data;
            clearing  <= 1'b1;
            clr_cnt   <= '0;
          end
          bfpd_pkg::REG_SRC_HEIGHT: begin
            src_height <= cfg_data;
            clearing   <= 1'b1;
            clr_cnt    <= '0;
          end
          bfpd_pkg::REG_DST_WIDTH: begin
            dst_width <= cfg_data;
            clearing  <= 1'b1;
            clr_cnt   <= '0;
          end
          bfpd_pkg::REG_DST_HEIGHT: begin
            dst_height <= cfg_data;
            clearing   <= 1'b1;
            clr_cnt    <= '0;
          end
          default: begin
          end
        endcase
      end else if (clearing) begin
        // reload the frame start from the current sizes while sweeping
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == IdxLast) begin
          clearing <= 1'b0;
        end
        src_col <= '0;
        src_row <= '0;
        dst_col <= '0;
        dst_row <= '0;
        col_err <= col_init[bfpd_pkg::IDX_W-1:0];
        row_err <= row_init[bfpd_pkg::IDX_W-1:0];
      end else if (take) begin
        if (line_end) begin
          src_col <= '0;
          dst_col <= '0;
          col_err <= col_init[bfpd_pkg::IDX_W-1:0];
          if (frame_end) begin
            src_row <= '0;
            dst_row <= '0;
            row_err <= row_init[bfpd_pkg::IDX_W-1:0];
          end else begin
            src_row <= src_row + 1'b1;
            if (row_end) begin
              dst_row <= dst_row + 1'b1;
              row_err <= row_sub[bfpd_pkg::IDX_W-1:0] + src_height[bfpd_pkg::IDX_W-1:0];
            end else begin
              row_err <= row_sub[bfpd_pkg::IDX_W-1:0];
            end
          end
        end else begin
          src_col <= src_col + 1'b1;
          if (col_end) begin
            dst_col <= dst_col + 1'b1;
            col_err <= col_sub[bfpd_pkg::IDX_W-1:0] + src_width[bfpd_pkg::IDX_W-1:0];
          end else begin
            col_err <= col_sub[bfpd_pkg::IDX_W-1:0];
          end
        end
      end
    end
  end

  // stage 1 payload: premultiplied pixel and box tags
  always_ff @(posedge clk) begin
    if (take) begin
      s1_idx  <= dst_col;
      s1_y    <= dst_row;
      s1_emit <= col_end && row_end;
      s1_last <= (({1'b0, dst_col} + 1'b1) == dst_width) &&
                 (({1'b0, dst_row} + 1'b1) == dst_height);
      s1_pa   <= src_pixel[31:24];
      s1_pr   <= bfpd_pkg::premult(src_pixel[23:16], src_pixel[31:24]);
      s1_pg   <= bfpd_pkg::premult(src_pixel[15:8], src_pixel[31:24]);
      s1_pb   <= bfpd_pkg::premult(src_pixel[7:0], src_pixel[31:24]);
    end
    fwd_data <= wb_data;
  end

  assign cur        = fwd_valid ? fwd_data : rdata;
  assign nsum.sum_a = cur.sum_a + {24'd0, s1_pa};
  assign nsum.sum_r = cur.sum_r + {24'd0, s1_pr};
  assign nsum.sum_g = cur.sum_g + {24'd0, s1_pg};
  assign nsum.sum_b = cur.sum_b + {24'd0, s1_pb};
  assign nsum.cnt   = cur.cnt + 1'b1;
  // a finished box leaves its slot empty for the next band
  assign wb_data    = s1_emit ? '0 : nsum;

  assign q_push       = s1_valid && s1_emit;
  assign q_data.acc   = nsum;
  assign q_data.x     = s1_idx;
  assign q_data.y     = s1_y;
  assign q_data.last  = s1_last;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (s1_valid) begin
      mem[s1_idx] <= wb_data;
    end
    if (take) begin
      rdata <= mem[dst_col];
    end
  end

endmodule

[rtl/bfpd_back.sv]
// ---------------------------------------------------------------------------
// bfpd_back
// Turns a finished box into a straight-alpha pixel with a shared divider.
// ---------------------------------------------------------------------------
module bfpd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  bfpd_pkg::box_t             q_head,
  output logic                       q_pop,
  input  logic                       pop,
  output logic                       empty,
  output logic [31:0]                out_pixel,
  output logic [bfpd_pkg::IDX_W-1:0] out_x,
  output logic [bfpd_pkg::IDX_W-1:0] out_y,
  output logic                       frame_last
);

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_DONE} state_t;

  state_t         state;
  bfpd_pkg::box_t box;
  logic [2:0]     step;
  logic           zero;
  logic           out_valid;
  logic [31:0]    ma, qr, qg, qb;
  logic [7:0]     cr, cg, cb;
  logic [31:0]    dividend, divisor, scaled;
  logic           div_done;
  logic [31:0]    div_q;
  logic [7:0]     clamped;

  assign q_pop   = (state == ST_IDLE) && !q_empty;
  assign empty   = !out_valid;
  assign clamped = (div_q > 32'd255) ? 8'hFF : div_q[7:0];

  always_comb begin
    case (step)
      3'd0:    begin dividend = box.acc.sum_a; divisor = {7'd0, box.acc.cnt}; end
      3'd1:    begin dividend = box.acc.sum_r; divisor = {7'd0, box.acc.cnt}; end
      3'd2:    begin dividend = box.acc.sum_g; divisor = {7'd0, box.acc.cnt}; end
      3'd3:    begin dividend = box.acc.sum_b; divisor = {7'd0, box.acc.cnt}; end
      3'd4:    begin dividend = scaled;        divisor = ma; end
      3'd5:    begin dividend = scaled;        divisor = ma; end
      default: begin dividend = scaled;        divisor = ma; end
    endcase
  end

  // mean premultiplied colour times 255, wrapping at 32 bits
  always_comb begin
    case (step)
      3'd4:    scaled = (qr << 8) - qr;
      3'd5:    scaled = (qg << 8) - qg;
      default: scaled = (qb << 8) - qb;
    endcase
  end

  bfpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
      zero      <= 1'b0;
    end else begin
      // ST_DONE refills the output register itself on a pop
      if (pop && out_valid && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            box   <= q_head;
            step  <= '0;
            zero  <= 1'b0;
            state <= ST_START;
          end
        end
        ST_START: begin
          if ((step == 3'd0) && (box.acc.cnt == '0)) begin
            zero  <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_done) begin
            step  <= step + 3'd1;
            state <= ST_START;
            case (step)
              3'd0: begin
                ma <= div_q;
                if (div_q == '0) begin
                  zero  <= 1'b1;
                  state <= ST_DONE;
                end
              end
              3'd1: qr <= div_q;
              3'd2: qg <= div_q;
              3'd3: qb <= div_q;
              3'd4: cr <= clamped;
              3'd5: cg <= clamped;
              default: begin
                cb    <= clamped;
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid || pop) begin
            out_valid  <= 1'b1;
            out_pixel  <= zero ? 32'd0 : {ma[7:0], cr, cg, cb};
            out_x      <= box.x;
            out_y      <= box.y;
            frame_last <= box.last;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/box_filter_premult_downscale.sv]
// ---------------------------------------------------------------------------
// box_filter_premult_downscale
// Area-average ARGB8888 downscaler with premultiplied accumulation.
// ---------------------------------------------------------------------------
// Source pixels enter in raster order through a push/full queue port, one
// per cycle while full is low. Each pixel is premultiplied and added into a
// per-destination-column accumulator memory (4096 entries); box edges follow
// floor(k*src/dst) and are tracked with running error terms, no division.
// When a box's bottom-right pixel arrives the finished sums go into a
// four-entry queue; full rises while three entries wait. The divide side
// pops one box at a time and runs seven serial divisions (mean alpha, three
// mean colours, three unpremultiply steps); that shared divider sets the
// sustained output rate, while pixels that close no box keep flowing at one
// per cycle until the queue fills. Results wait in an output register read
// with empty/pop. After reset, and after every configuration transaction to
// a listed register, the frame restarts and a clearing pass zeroes the
// accumulator memory with full held high; configuration transactions are
// always taken (cfg_ready is tied high). With invalid sizes (zero, above
// 4096, or destination larger than source) pixels are accepted and
// dropped.
module box_filter_premult_downscale (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bfpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfpd_pkg::DIM_W-1:0]         cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic [31:0]                        src_pixel,
  output logic                               empty,
  input  logic                               pop,
  output logic [31:0]                        out_pixel,
  output logic [bfpd_pkg::IDX_W-1:0]         out_x,
  output logic [bfpd_pkg::IDX_W-1:0]         out_y,
  output logic                               frame_last
);

`include "box_filter_premult_downscale_macros.svh"

  logic                           cfg_wr;
  logic                           q_push;
  logic                           q_pop;
  logic                           q_empty;
  logic [bfpd_pkg::Q_CNT_W-1:0]   q_count;
  bfpd_pkg::box_t                 q_wdata;
  bfpd_pkg::box_t                 q_head;

  // configuration never stalls
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // accumulate side: walk the raster, sum boxes, hand off finished ones
  bfpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .src_pixel (src_pixel),
    .q_count   (q_count),
    .full      (full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // hold finished boxes until the divide side is free
  bfpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_empty (q_empty),
    .count   (q_count)
  );

  // divide side: mean alpha, mean colours, unpremultiply, clamp
  bfpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_pixel  (out_pixel),
    .out_x      (out_x),
    .out_y      (out_y),
    .frame_last (frame_last)
  );

  // the input throttle must leave room for the box in flight
  `BFPD_ASSERT_IMPL(a_queue_no_overflow, q_push, q_count != bfpd_pkg::Q_FULL_CNT)
  // the divide side only drains a queue that holds something
  `BFPD_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty)
  // a register transaction restarts the frame behind a clearing pass
  `BFPD_ASSERT_NEXT(a_cfg_restart, cfg_wr && (cfg_index <= bfpd_pkg::REG_DST_HEIGHT), full)

endmodule
